// ----- rtl/otc_pkg.sv -----
// Shared types, byte codes and the 5x7 font table for the OLED text
// cursor byte generator. No dependencies.
package otc_pkg;

  // Request types
  localparam logic REQ_PRINT  = 1'b0;
  localparam logic REQ_CURSOR = 1'b1;

  // Controller byte codes
  localparam logic [7:0] CTRL_CMD      = 8'h00;
  localparam logic [7:0] CTRL_DATA     = 8'h40;
  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0] NIBBLE_MASK   = 8'h0F;
  localparam logic [7:0] BLANK_COLUMN  = 8'h00;
  localparam logic [7:0] CHAR_FIRST    = 8'h20;
  localparam logic [7:0] CHAR_LAST     = 8'h7E;

  // Byte sequencer steps: six command bytes, then seven data bytes
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_CMD_CTRL0  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_CMD_PAGE   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CMD_CTRL1  = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CMD_COLLO  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_CMD_CTRL2  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_CMD_COLHI  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_DATA_CTRL  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_GLYPH_0    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DATA_BLANK = 4'd12;

  localparam int GLYPH_COUNT = 95;
  localparam int CMD_FIFO_DEPTH = 4;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
    logic [7:0] cursor_page;
    logic [7:0] cursor_column;
  } otc_in_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       transfer_end;
    logic       last;
  } otc_out_t;

  // Classified work for the byte sequencer
  typedef struct packed {
    logic       do_cursor;
    logic       do_print;
    logic [2:0] page;
    logic [7:0] column;
    logic [6:0] glyph;
  } otc_cmd_t;

  // Font: column 0 in the top byte
  localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040403C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
    40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  // One font column; column index 0..4, unused rows read as blank
  function automatic logic [7:0] glyph_col(input logic [6:0] idx, input logic [2:0] k);
    logic [39:0] row;
    logic [7:0]  col;
    row = (idx < 7'(GLYPH_COUNT)) ? GLYPH_ROM[idx] : 40'h0;
    case (k)
      3'd0:    col = row[39:32];
      3'd1:    col = row[31:24];
      3'd2:    col = row[23:16];
      3'd3:    col = row[15:8];
      3'd4:    col = row[7:0];
      default: col = BLANK_COLUMN;
    endcase
    return col;
  endfunction

endpackage

// ----- rtl/otc_front.sv -----
// Front end: accepts requests, keeps the text cursor and classifies each
// request into a sequencer command. Depends on otc_pkg.
module otc_front import otc_pkg::*; #(
  parameter int PANEL_WIDTH = 128,
  parameter int PAGE_COUNT  = 8,
  parameter int GLYPH_PITCH = 6
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  otc_in_t  in_data,
  output logic     in_full,
  input  logic     cmd_full,
  output logic     cmd_push,
  output otc_cmd_t cmd_data
);

  localparam logic [2:0] PAGE_LAST = 3'(PAGE_COUNT - 1);

  logic [2:0] page_r, page_nxt;
  logic [7:0] column_r, column_nxt;
  logic [2:0] page_clamp, page_wrap;
  logic [7:0] col_clamp;
  logic       wrap;
  logic       code_ok;

  assign in_full  = cmd_full;
  assign cmd_push = in_push && !cmd_full;

  // Clamp cursor request fields
  assign page_clamp = (in_data.cursor_page >= 8'(PAGE_COUNT)) ? PAGE_LAST
                                                              : in_data.cursor_page[2:0];
  assign col_clamp  = (in_data.cursor_column >= 8'(PANEL_WIDTH)) ? 8'h00
                                                                 : in_data.cursor_column;

  // Right-edge check and next page with wrap
  assign wrap      = ({1'b0, column_r} + 9'(GLYPH_PITCH)) > 9'(PANEL_WIDTH);
  assign page_wrap = (({1'b0, page_r} + 4'd1) >= 4'(PAGE_COUNT)) ? 3'd0 : (page_r + 3'd1);
  assign code_ok   = (in_data.char_code >= CHAR_FIRST) && (in_data.char_code <= CHAR_LAST);

  // Classify the request and compute the next cursor
  always_comb begin
    page_nxt   = page_r;
    column_nxt = column_r;
    cmd_data   = '0;
    if (in_data.req_type == REQ_CURSOR) begin
      cmd_data.do_cursor = 1'b1;
      cmd_data.page      = page_clamp;
      cmd_data.column    = col_clamp;
      page_nxt           = page_clamp;
      column_nxt         = col_clamp;
    end else begin
      cmd_data.do_print  = 1'b1;
      cmd_data.do_cursor = wrap;
      cmd_data.page      = wrap ? page_wrap : page_r;
      cmd_data.column    = 8'h00;
      cmd_data.glyph     = code_ok ? 7'(in_data.char_code - CHAR_FIRST) : 7'd0;
      page_nxt           = wrap ? page_wrap : page_r;
      column_nxt         = (wrap ? 8'h00 : column_r) + 8'(GLYPH_PITCH);
    end
  end

  // Hold the cursor; update it on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r   <= 3'd0;
      column_r <= 8'h00;
    end else if (cmd_push) begin
      page_r   <= page_nxt;
      column_r <= column_nxt;
    end
  end

  a_page_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, page_r} < 4'(PAGE_COUNT)))
    else $error("cursor page beyond last page");

endmodule

// ----- rtl/otc_cmd_fifo.sv -----
// Short command queue between front end and byte sequencer.
// Depends on otc_pkg.
module otc_cmd_fifo import otc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  otc_cmd_t push_data,
  output logic     full,
  input  logic     pop,
  output otc_cmd_t head,
  output logic     empty
);

  localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  otc_cmd_t         mem_r [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(CMD_FIFO_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(CMD_FIFO_DEPTH)))
    else $error("command queue count overflow");

endmodule

// ----- rtl/otc_back.sv -----
// Back end: walks each queued command through its byte sequence, one byte
// per cycle unless stalled, into an output register. Depends on otc_pkg.
module otc_back import otc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  otc_cmd_t head,
  input  logic     head_empty,
  output logic     head_pop,
  output otc_out_t out_data,
  output logic     out_empty,
  input  logic     out_pop
);

  logic [STEP_W-1:0] step_r, step_nxt, step_cur, step_end;
  logic              started_r, started_nxt;
  otc_out_t          out_data_r, out_data_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free, fire;
  otc_out_t          beat;

  assign slot_free = !out_valid_r || out_pop;
  assign fire      = !head_empty && slot_free;
  assign step_cur  = started_r ? step_r : (head.do_cursor ? STEP_CMD_CTRL0 : STEP_DATA_CTRL);
  assign step_end  = head.do_print ? STEP_DATA_BLANK : STEP_CMD_COLHI;
  assign head_pop  = fire && (step_cur == step_end);

  // Build the beat for the current step
  always_comb begin
    beat      = '0;
    beat.last = (step_cur == step_end);
    case (step_cur)
      STEP_CMD_CTRL0, STEP_CMD_CTRL1, STEP_CMD_CTRL2: beat.byte_value = CTRL_CMD;
      STEP_CMD_PAGE: begin
        beat.byte_value   = CMD_PAGE_BASE | {5'd0, head.page};
        beat.transfer_end = 1'b1;
      end
      STEP_CMD_COLLO: begin
        beat.byte_value   = head.column & NIBBLE_MASK;
        beat.transfer_end = 1'b1;
      end
      STEP_CMD_COLHI: begin
        beat.byte_value   = CMD_COL_HIGH | {4'd0, head.column[7:4]};
        beat.transfer_end = 1'b1;
      end
      STEP_DATA_CTRL: beat.byte_value = CTRL_DATA;
      STEP_DATA_BLANK: begin
        beat.byte_value   = BLANK_COLUMN;
        beat.transfer_end = 1'b1;
      end
      default: beat.byte_value = glyph_col(head.glyph, 3'(step_cur - STEP_GLYPH_0));
    endcase
  end

  // Sequencer and output register next values
  always_comb begin
    step_nxt      = step_r;
    started_nxt   = started_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r;
    if (slot_free) begin
      out_valid_nxt = fire;
      out_data_nxt  = beat;
    end
    if (fire) begin
      if (head_pop) begin
        started_nxt = 1'b0;
      end else begin
        started_nxt = 1'b1;
        step_nxt    = step_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      started_r   <= started_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_data  = out_data_r;
  assign out_empty = !out_valid_r;

  a_last_ends_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last) |-> out_data_r.transfer_end)
    else $error("last beat does not close a transfer");

  a_pop_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |=> (out_valid_r && out_data_r.last))
    else $error("command retired without a last beat");

  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |-> (step_r <= STEP_DATA_BLANK))
    else $error("sequencer step out of range");

endmodule

// ----- rtl/oled_text_cursor_byte_generator.sv -----
// An accepted request is written into the command queue, and its first
// byte is then registered into out_data when the result side is free.
// Throughput: 6 bytes for a cursor request, 7 for a character, 13 when the
// character wraps; the sequencer emits one byte per cycle while out_data is
// free, and a four-entry command queue lets new requests enter while bytes stream out.
// Reset (synchronous, rst_n low): cursor to page 0 column 0, queues empty.
module oled_text_cursor_byte_generator import otc_pkg::*; #(
  parameter int PANEL_WIDTH = 128,
  parameter int PAGE_COUNT  = 8,
  parameter int GLYPH_PITCH = 6
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  otc_in_t  in_data,
  output logic     in_full,
  output logic     out_empty,
  input  logic     out_pop,
  output otc_out_t out_data
);

  otc_cmd_t cmd_in, cmd_head;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;

  // Classify requests and track the cursor
  otc_front #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PAGE_COUNT  (PAGE_COUNT),
    .GLYPH_PITCH (GLYPH_PITCH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .cmd_full (cmd_full),
    .cmd_push (cmd_push),
    .cmd_data (cmd_in)
  );

  // Decouple front end from sequencer
  otc_cmd_fifo u_cmd_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .head      (cmd_head),
    .empty     (cmd_empty)
  );

  // Emit bytes
  otc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (cmd_head),
    .head_empty (cmd_empty),
    .head_pop   (cmd_pop),
    .out_data   (out_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop)
  );

endmodule
